// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with the block's own clock and reset names.
`define ASSERT_DEFAULT(label, prop, msg) \
   `ASSERT_CLKRST(label, clock, reset, prop, msg)

`endif

// ===== rtl/mss_pkg.sv =====
`default_nettype none

package mss_pkg;

   // Number of groups that own a sequence counter.
   localparam int NUM_GROUPS = 16;

   localparam int GROUP_W   = 4;
   localparam int SEQ_W     = 64;
   localparam int BITMAP_W  = 16;
   localparam int SESSION_W = 64;

   // Index width into the counter array.
   localparam int GRP_IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   typedef struct packed {
      logic [GROUP_W-1:0] group_index;
      logic               first_of_packet;
      logic               last_of_packet;
      logic               empty_packet;
   } req_type;

   typedef struct packed {
      logic [GROUP_W-1:0]   stamped_group;
      logic [SEQ_W-1:0]     sequence_number;
      logic [BITMAP_W-1:0]  packet_bitmap;
      logic                 packet_done;
      logic [SESSION_W-1:0] session_stamp;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/mss_controller.sv =====
`default_nettype none

module mss_controller import mss_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            // The result may only be written once the output register is free.
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/mss_datapath.sv =====
`default_nettype none

module mss_datapath import mss_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [SESSION_W-1:0] csr_wr_data,
   input  wire cmd_type              cmd,
   output status_type                status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data
);

   localparam logic [GROUP_W:0] GRP_LIMIT = (GROUP_W+1)'(NUM_GROUPS);

   req_type              req_ff;
   logic [SEQ_W-1:0]     counters_ff [NUM_GROUPS];
   logic [SEQ_W-1:0]     counter_in;
   logic [BITMAP_W-1:0]  bitmap_ff;
   logic [BITMAP_W-1:0]  bitmap_in;
   logic [SESSION_W-1:0] session_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   logic                 in_range;
   logic [GRP_IDX_W-1:0] grp_idx;
   logic [BITMAP_W-1:0]  bm_base;
   logic [BITMAP_W-1:0]  bm_new;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   always_comb begin
      in_range   = {1'b0, req_ff.group_index} < GRP_LIMIT;
      grp_idx    = req_ff.group_index[GRP_IDX_W-1:0];
      counter_in = counters_ff[grp_idx] + SEQ_W'(1);
      bm_base    = req_ff.first_of_packet ? '0 : bitmap_ff;
      bm_new     = in_range ? (bm_base | (BITMAP_W'(1) << req_ff.group_index)) : bm_base;

      if (req_ff.empty_packet) begin
         rsp_in.stamped_group   = '0;
         rsp_in.sequence_number = '0;
         rsp_in.packet_bitmap   = '0;
         rsp_in.packet_done     = 1'b1;
         bitmap_in              = '0;
      end else begin
         rsp_in.stamped_group   = req_ff.group_index;
         rsp_in.sequence_number = in_range ? counter_in : '0;
         rsp_in.packet_bitmap   = bm_new;
         rsp_in.packet_done     = req_ff.last_of_packet;
         bitmap_in              = req_ff.last_of_packet ? '0 : bm_new;
      end
      rsp_in.session_stamp = session_ff;

      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GROUPS; i++) begin
            counters_ff[i] <= '0;
         end
         bitmap_ff    <= '0;
         session_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit && !req_ff.empty_packet && in_range) begin
            counters_ff[grp_idx] <= counter_in;
         end
         if (cmd.commit) begin
            bitmap_ff <= bitmap_in;
         end
         if (csr_wr_en) begin
            session_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/multigroup_sequence_stamper_unit.sv =====
// Flow: an accepted transaction is captured into the request register and its result
// is committed to the output register once that register is free, so it waits while
// the previous result is still stalled in the output register.
// The controller takes no new transaction until the captured one is committed, as it
// alternates between its capture and read-modify-write steps.
// Reset (synchronous, active high) clears all group counters, the packet bitmap,
// the session identifier and the output valid flag; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module multigroup_sequence_stamper_unit import mss_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel: one header group entry per transaction.
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   // Response channel: one stamped result per request transaction.
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   // Session identifier register.
   input  wire logic                 csr_wr_en,
   input  wire logic [SESSION_W-1:0] csr_wr_data
);

   // The controller decides when a request transaction is captured and when the
   // captured entry is committed. Committing performs the read-modify-write of
   // the group counter, updates the packet bitmap and loads the output register
   // in the same cycle. The output register separates the two channels, so a
   // new request is taken while an earlier result still waits on rsp.
   cmd_type    cmd;
   status_type status;

   mss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the sixteen 64-bit counters in flops, the bitmap
   // accumulator, the session register and the output register. An empty
   // packet leaves the counters alone and clears the bitmap; an entry that
   // carries the last mark also clears the bitmap after stamping.
   mss_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // Only one entry is in flight: after an accepted transaction the input stalls.
   `ASSERT_DEFAULT(a_one_in_flight, (req_valid && !req_stall) |=> req_stall,
                   "request accepted while an entry is still in flight")

   // A result is never written over one that is still stalled on the output.
   `ASSERT_DEFAULT(a_no_overwrite, cmd.commit |-> (!rsp_valid || !rsp_stall),
                   "commit while the output register is held")

   // A fresh result is first seen valid after its request was captured into the
   // request register and then committed to the output register.
   `ASSERT_DEFAULT(a_result_latency, $rose(rsp_valid) |-> $past(cmd.capture, 2),
                   "result raised without a matching captured request")

endmodule

`default_nettype wire

// ===== test/multigroup_sequence_stamper_unit_test.sv =====
`default_nettype none

// Self-checking bench for the per-group sequence stamper.
module multigroup_sequence_stamper_unit_test;
   import mss_pkg::*;

   // Random header entries spread over the phases that follow the directed part.
   localparam int RANDOM_ENTRIES = 850;
   localparam int RANDOM_PHASES  = 5;
   // Cycles allowed after the last result before the verdict or a register write.
   localparam int SETTLE_CYCLES  = 8;
   // Far beyond the slowest correct run: every transaction with the longest sender
   // gap and receiver stall on each one of them, several times over.
   localparam int TIME_LIMIT     = 4000000;

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_RUNS
   } stall_pattern_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [SESSION_W-1:0] csr_wr_data = '0;

   // Our own copy of the block's state: one counter per group, the bitmap
   // gathered so far in the current packet, and the session identifier.
   logic [SEQ_W-1:0]     group_count [NUM_GROUPS];
   logic [BITMAP_W-1:0]  packet_bits;
   logic [SESSION_W-1:0] session_copy;

   // Header entries not yet offered, and stamps due back in order.
   req_type              pending_entries [$];
   rsp_type              awaited_stamps [$];
   int                   mismatch_count = 0;

   // Sender burst shaping.
   int                   burst_left = 0;
   int                   gap_left   = 0;

   // Receiver stall shaping.
   stall_pattern_type    stall_pattern = STALL_NONE;
   int                   pattern_left  = 0;
   int                   stall_phase   = 0;
   int                   stall_run     = 0;
   logic                 run_stalled   = 1'b0;

   multigroup_sequence_stamper_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the stamp for one accepted header entry and advances the state.
   // An empty packet leaves every counter alone and clears the bitmap. Otherwise
   // the group's counter is pre-incremented (wrapping naturally at 64 bits) and
   // its bit joins the bitmap, which restarts on a first mark and is cleared
   // once a last mark has gone through.
   function automatic rsp_type stamp_entry(req_type entry);
      rsp_type             stamp;
      logic [BITMAP_W-1:0] bits;
      stamp = '0;
      stamp.session_stamp = session_copy;
      if (entry.empty_packet) begin
         packet_bits = '0;
         stamp.packet_done = 1'b1;
         return stamp;
      end
      bits = entry.first_of_packet ? '0 : packet_bits;
      stamp.stamped_group = entry.group_index;
      if (32'(entry.group_index) < NUM_GROUPS) begin
         group_count[entry.group_index] = group_count[entry.group_index] + SEQ_W'(1);
         stamp.sequence_number = group_count[entry.group_index];
         bits[entry.group_index] = 1'b1;
      end
      packet_bits = entry.last_of_packet ? '0 : bits;
      stamp.packet_bitmap = bits;
      stamp.packet_done = entry.last_of_packet;
      return stamp;
   endfunction

   task automatic push_entry(input logic [GROUP_W-1:0] group, input logic first,
                             input logic last, input logic empty);
      req_type entry;
      entry.group_index     = group;
      entry.first_of_packet = first;
      entry.last_of_packet  = last;
      entry.empty_packet    = empty;
      pending_entries.push_back(entry);
   endtask

   // A well-formed packet: first mark on the opening entry, last mark on the
   // closing one, random groups that may repeat.
   task automatic queue_packet(input int entries);
      for (int k = 0; k < entries; k++) begin
         push_entry(GROUP_W'($urandom_range(0, NUM_GROUPS - 1)), k == 0,
                    k == entries - 1, 1'b0);
      end
   endtask

   // Mostly well-formed packets with random content, the rest empty packets
   // carrying stray marks and loose entries with arbitrary marks.
   task automatic queue_random_phase(input int target);
      int      queued;
      int      pick;
      int      entries;
      req_type entry;
      queued = 0;
      while (queued < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            entries = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 6);
            queue_packet(entries);
            queued += entries;
         end else begin
            entry = 7'($urandom_range(0, 127));
            entry.empty_packet = (pick < 17) || ($urandom_range(0, 5) == 0);
            pending_entries.push_back(entry);
            queued++;
         end
      end
   endtask

   // Holds the thread until every queued transaction has been accepted and every
   // stamp has come back, then lets the pipeline settle.
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (pending_entries.size() != 0 || req_valid || awaited_stamps.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Pulses the register write enable with the new value; the block is idle by then.
   task automatic write_session(input logic [SESSION_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      session_copy = value;
   endtask

   // Main sequence: reset, a directed packet set under the reset session value,
   // then random phases, each under a new session identifier. Each phase starts
   // only once the last one has fully drained, so the sender also pauses until
   // every expected stamp has come back.
   initial begin
      logic [SESSION_W-1:0] session_values [RANDOM_PHASES];
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_count[g] = '0;
      end
      packet_bits  = '0;
      session_copy = '0;

      // Directed part. An empty packet that carries a first mark must still
      // stamp nothing and leave the counters alone.
      push_entry(4'hA, 1'b1, 1'b0, 1'b1);
      // Single-entry packets at both ends of the group range.
      push_entry(4'h0, 1'b1, 1'b1, 1'b0);
      push_entry(4'hF, 1'b1, 1'b1, 1'b0);
      // One packet naming every group, in descending order, for a full bitmap.
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         push_entry(GROUP_W'(g), g == NUM_GROUPS - 1, g == 0, 1'b0);
      end
      // An entry without a first mark after a completed packet starts afresh.
      push_entry(4'h5, 1'b0, 1'b0, 1'b0);
      // An empty packet in the middle of one clears the gathered bitmap.
      push_entry(4'hF, 1'b0, 1'b1, 1'b1);
      push_entry(4'h6, 1'b0, 1'b1, 1'b0);
      // A second first mark restarts the bitmap; the group also repeats.
      push_entry(4'h9, 1'b1, 1'b0, 1'b0);
      push_entry(4'h9, 1'b1, 1'b1, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      session_values[0] = '1;
      session_values[1] = {SESSION_W/2{2'b01}};
      session_values[2] = {SESSION_W/2{2'b10}};
      session_values[3] = {$urandom, $urandom};
      session_values[4] = '0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_session(session_values[p]);
         @(negedge clock);
         queue_random_phase(RANDOM_ENTRIES / RANDOM_PHASES);
         wait_for_drain();
      end

      if (mismatch_count == 0 && awaited_stamps.size() == 0) begin
         $display("multigroup_sequence_stamper_unit test passed");
      end else begin
         $display("multigroup_sequence_stamper_unit test failed");
      end
      $finish;
   end

   // Driver. A transaction is accepted at an edge where valid is high and stall
   // low; its stamp is predicted there. A stalled transaction is held unchanged.
   // Otherwise the next entry goes out unless a gap between bursts is running.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_stamps.push_back(stamp_entry(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_entries.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_entries.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // Long bursts now and then give stretches with no idling.
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver. Each accepted result transaction is checked against
   // the oldest awaited stamp, field by field. The stall pattern switches now
   // and then between none, coin tosses, a fixed period and long runs.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_stamps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("rsp transaction with nothing awaited: %p", rsp_data);
            end
         end else begin
            want = awaited_stamps.pop_front();
            if (rsp_data.stamped_group !== want.stamped_group
                || rsp_data.sequence_number !== want.sequence_number
                || rsp_data.packet_bitmap !== want.packet_bitmap
                || rsp_data.packet_done !== want.packet_done
                || rsp_data.session_stamp !== want.session_stamp) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("rsp mismatch: expected group %0d seq %h bitmap %h done %b session %h",
                           want.stamped_group, want.sequence_number, want.packet_bitmap,
                           want.packet_done, want.session_stamp);
                  $display("              actual   group %0d seq %h bitmap %h done %b session %h",
                           rsp_data.stamped_group, rsp_data.sequence_number,
                           rsp_data.packet_bitmap, rsp_data.packet_done,
                           rsp_data.session_stamp);
               end
            end
         end
      end

      if (pattern_left == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(20, 200);
      end
      pattern_left--;
      case (stall_pattern)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_COIN: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         STALL_PERIODIC: begin
            stall_phase = (stall_phase + 1) % 3;
            rsp_stall <= (stall_phase == 0);
         end
         default: begin
            if (stall_run == 0) begin
               stall_run   = $urandom_range(1, 15);
               run_stalled = ~run_stalled;
            end
            stall_run--;
            rsp_stall <= run_stalled;
         end
      endcase
   end

   // Watchdog for a hung handshake.
   initial begin
      #TIME_LIMIT;
      $display("multigroup_sequence_stamper_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/mss_pkg.sv
rtl/mss_controller.sv
rtl/mss_datapath.sv
rtl/multigroup_sequence_stamper_unit.sv
test/multigroup_sequence_stamper_unit_test.sv
